// File: hw/rtl/assert_macros.svh
// Assertion helper macros for the hash counter RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/lphc_pkg.sv
// Shared types and constants for the linear-probing hash counter.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package lphc_pkg;

  // Table size must be a power of two: the home slot is the key's low bits.
  localparam int TABLE_ENTRIES = 4096;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int KEY_W         = 32;
  localparam int CNT_W         = 32;
  // Entry layout: {valid, key, count}
  localparam int ENTRY_W       = 1 + KEY_W + CNT_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;    // write an empty entry at the clear pointer
    logic start;  // latch input beat, read home slot
    logic look;   // evaluate read entry, advance probe
    logic emit;   // load result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic resolved;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/lphc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lphc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/lphc_ctrl.sv
// Sequencer for the hash counter: clear sweep, accept, probe loop, result.
// Depends on lphc_pkg.
`timescale 1ns / 1ps

module lphc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  lphc_pkg::sts_t  sts,
  output lphc_pkg::cmd_t  cmd,
  output lphc_pkg::state_t state
);

  lphc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lphc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      lphc_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = lphc_pkg::ST_IDLE;
        end
      end
      lphc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = lphc_pkg::ST_LOOK;
        end
      end
      lphc_pkg::ST_LOOK: begin
        cmd.look = 1'b1;
        if (sts.resolved) begin
          state_nxt = lphc_pkg::ST_DONE;
        end
      end
      lphc_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = lphc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lphc_pkg::ST_CLEAR;
      end
    endcase
  end

  assign state = state_r;

endmodule

// File: hw/rtl/lphc_dp.sv
// Datapath: slot RAM, probe pointer, hit/empty compare, count update,
// result and output registers. Depends on lphc_pkg and lphc_ram.
`timescale 1ns / 1ps

module lphc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lphc_pkg::cmd_t                    cmd,
  output lphc_pkg::sts_t                    sts,
  input  logic                              in_op,
  input  logic signed [lphc_pkg::KEY_W-1:0] in_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lphc_pkg::CNT_W-1:0]        out_count,
  output logic                              out_found,
  output logic                              out_table_full
);

  logic                              op_r;
  logic signed [lphc_pkg::KEY_W-1:0] key_r;
  logic [lphc_pkg::SLOT_W-1:0]       addr_r, probe_r, clr_addr_r;
  logic [lphc_pkg::CNT_W-1:0]        res_count_r, out_count_r;
  logic                              res_found_r, res_full_r;
  logic                              out_found_r, out_full_r, out_valid_r;

  logic                              wr_en;
  logic [lphc_pkg::SLOT_W-1:0]       wr_addr, rd_addr;
  logic [lphc_pkg::ENTRY_W-1:0]      wr_data, rd_data;

  logic                              e_valid, empty, hit, exhausted, resolved;
  logic [lphc_pkg::KEY_W-1:0]        e_key;
  logic [lphc_pkg::CNT_W-1:0]        e_cnt, inc_cnt, new_cnt;
  logic                              is_insert;

  lphc_ram #(
    .WIDTH (lphc_pkg::ENTRY_W),
    .DEPTH (lphc_pkg::TABLE_ENTRIES)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign e_valid = rd_data[lphc_pkg::ENTRY_W-1];
  assign e_key   = rd_data[lphc_pkg::KEY_W+lphc_pkg::CNT_W-1:lphc_pkg::CNT_W];
  assign e_cnt   = rd_data[lphc_pkg::CNT_W-1:0];

  assign is_insert = (op_r == lphc_pkg::OP_INSERT);
  assign empty     = !e_valid;
  assign hit       = e_valid && (e_key == $unsigned(key_r));
  // last slot of a full wrap examined
  assign exhausted = &probe_r;
  assign resolved  = empty || hit || exhausted;

  // saturating increment
  assign inc_cnt = (&e_cnt) ? e_cnt : e_cnt + lphc_pkg::CNT_W'(1);
  assign new_cnt = hit ? inc_cnt : lphc_pkg::CNT_W'(1);

  // home slot on start, else the next slot in the probe sequence (wraps)
  assign rd_addr = cmd.start ? in_key[lphc_pkg::SLOT_W-1:0]
                             : addr_r + lphc_pkg::SLOT_W'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = {1'b1, key_r, new_cnt};
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (cmd.look && is_insert && (hit || empty)) begin
      wr_en = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + lphc_pkg::SLOT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= in_op;
      key_r   <= in_key;
      addr_r  <= in_key[lphc_pkg::SLOT_W-1:0];
      probe_r <= '0;
    end else if (cmd.look && !resolved) begin
      addr_r  <= addr_r + lphc_pkg::SLOT_W'(1);
      probe_r <= probe_r + lphc_pkg::SLOT_W'(1);
    end

    if (cmd.look && resolved) begin
      res_found_r <= hit;
      res_full_r  <= is_insert && !hit && !empty;
      if (hit) begin
        res_count_r <= is_insert ? inc_cnt : e_cnt;
      end else if (empty && is_insert) begin
        res_count_r <= lphc_pkg::CNT_W'(1);
      end else begin
        res_count_r <= '0;
      end
    end

    if (cmd.emit) begin
      out_count_r <= res_count_r;
      out_found_r <= res_found_r;
      out_full_r  <= res_full_r;
    end
  end

  assign sts.clr_last = &clr_addr_r;
  assign sts.resolved = resolved;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_count      = out_count_r;
  assign out_found      = out_found_r;
  assign out_table_full = out_full_r;

endmodule

// File: hw/rtl/linear_probe_hash_counter_top.sv
// Each input beat probes P slots (1..TABLE_ENTRIES), and in_stall stays high until its
// result is emitted. The probe loop reads one slot RAM entry per cycle.
// Reset: synchronous, active low; afterwards a clearing pass writes every slot
// (TABLE_ENTRIES = 4096 slots) with in_stall high before the first input beat.
// Depends on lphc_pkg, lphc_ctrl, lphc_dp, lphc_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_probe_hash_counter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic signed [lphc_pkg::KEY_W-1:0] in_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lphc_pkg::CNT_W-1:0]        out_count,
  output logic                              out_found,
  output logic                              out_table_full
);

  lphc_pkg::cmd_t   cmd;
  lphc_pkg::sts_t   sts;
  lphc_pkg::state_t state;

  lphc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  lphc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_count      (out_count),
    .out_found      (out_found),
    .out_table_full (out_table_full)
  );

  // accepted beat always starts a probe
  `ASSERT_NEXT(a_accept_probe, in_valid && !in_stall, state == lphc_pkg::ST_LOOK)
  // a new result only follows the result state
  `ASSERT_SAME(a_emit_src, $rose(out_valid), $past(state == lphc_pkg::ST_DONE))
  // a failed insert reports nothing found
  `ASSERT_SAME(a_full_clean, out_valid && out_table_full, !out_found && out_count == '0)
  // a key that was present always has a nonzero count
  `ASSERT_SAME(a_found_cnt, out_valid && out_found, out_count != '0)

endmodule
